// ===== rtl/core/qdv_pkg.sv =====
// ============================================================================
// qdv_pkg
// Shared types and constants for the quadrature decoder with velocity.
// ============================================================================
`default_nettype none

package qdv_pkg;

    localparam int TS_W   = 48;
    localparam int CNT_W  = 32;
    localparam int ENC_W  = 2;
    localparam int PPR_W  = 16;
    localparam int WIN_W  = 24;

    // 60 * 1e6 * 256
    localparam logic [33:0] RPM_Q8_SCALE = 34'd15360000000;

    localparam logic [1:0] PIN_A    = 2'd0;
    localparam logic [1:0] PIN_B    = 2'd1;
    localparam logic [1:0] PIN_IDX  = 2'd2;
    localparam logic [1:0] PIN_NONE = 2'd3;

    localparam logic [2:0] REG_PPR  = 3'd0;
    localparam logic [2:0] REG_ABS  = 3'd1;
    localparam logic [2:0] REG_SWAP = 3'd2;
    localparam logic [2:0] REG_IDX  = 3'd3;
    localparam logic [2:0] REG_WIN  = 3'd4;
    localparam logic [2:0] REG_MIN  = 3'd5;

    typedef struct packed {
        logic [PPR_W-1:0] pulses_per_rev;
        logic             absolute_mode;
        logic             chan_swap;
        logic             index_enable;
        logic [WIN_W-1:0] velocity_window_us;
        logic [WIN_W-1:0] min_update_us;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic edge_apply;   // apply pin edge to state
        logic tick_start;   // latch tick, check interval
        logic scan_load;    // issue ring read for current scan index
        logic scan_eval;    // evaluate returned sample
        logic end_load;     // load newest and oldest samples
        logic mul_start;    // latch newest sample; start numerator and denominator
        logic div_step;     // one restoring division step
        logic vel_store;    // write velocity and last time
        logic time_store;   // write last time only
        logic snap;         // capture snapshot and clear flags
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic due;          // interval passed
        logic scan_more;    // more samples to scan
        logic scan_hit;     // sample inside window
        logic found;
        logic dt_zero;
        logic div_done;
    } sts_t;

    // -1 reverse, +1 forward, 0 none; err for illegal jump
    function automatic logic [1:0] qdv_decode(input logic [3:0] code);
        logic [1:0] r;
        begin
            r = 2'b00;
            case (code)
                4'd1, 4'd7, 4'd8, 4'd14:  r = 2'b01;
                4'd2, 4'd4, 4'd11, 4'd13: r = 2'b10;
                4'd3, 4'd6, 4'd9, 4'd12:  r = 2'b11;
                default:                  r = 2'b00;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qdv_ctrl.sv =====
// ============================================================================
// qdv_ctrl
// Sequencer for edge updates, window scan, velocity division and snapshot.
// ============================================================================
`default_nettype none

module qdv_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           in_tick,
    input  wire logic           in_valid_enc,
    input  wire qdv_pkg::sts_t  sts,
    input  wire logic           out_free,
    output logic                busy,
    output qdv_pkg::cmd_t       cmd
);
    import qdv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_TICK, S_SREQ, S_SEVAL, S_ENDS, S_MUL, S_MUL2, S_DIV,
        S_VST, S_SNAP
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  ;
            S_EDGE:  cmd.edge_apply = 1'b1;
            S_TICK:  cmd.tick_start = 1'b1;
            S_SREQ:  cmd.scan_load  = 1'b1;
            S_SEVAL: cmd.scan_eval  = 1'b1;
            S_ENDS:  cmd.end_load   = 1'b1;
            S_MUL:   cmd.mul_start  = 1'b1;
            S_MUL2:  ;
            S_DIV:   cmd.div_step   = 1'b1;
            S_VST:   cmd.vel_store  = 1'b1;
            S_SNAP:  cmd.snap       = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_fire && in_valid_enc)
                        state_reg <= in_tick ? S_TICK : S_EDGE;
                S_EDGE:  state_reg <= S_IDLE;
                S_TICK:  state_reg <= sts.due ? (sts.scan_more ? S_SREQ : S_VST) : S_SNAP;
                S_SREQ:  state_reg <= S_SEVAL;
                S_SEVAL:
                    if (sts.scan_hit && sts.scan_more)
                        state_reg <= S_SREQ;
                    else if (sts.found || sts.scan_hit)
                        state_reg <= S_ENDS;
                    else
                        state_reg <= S_VST;
                S_ENDS:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_MUL2;
                S_MUL2:  state_reg <= sts.dt_zero ? S_VST : S_DIV;
                S_DIV:   if (sts.div_done) state_reg <= S_VST;
                S_VST:   state_reg <= S_SNAP;
                S_SNAP:  if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qdv_datapath.sv =====
// ============================================================================
// qdv_datapath
// Per-encoder state, sample ring memory, multiplier and serial divider.
// ============================================================================
`default_nettype none

module qdv_datapath #(
    parameter int NUM_ENCODERS = 4,
    parameter int SAMPLE_DEPTH = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qdv_pkg::cfg_t             cfg,
    input  wire logic                      in_fire,
    input  wire logic [qdv_pkg::ENC_W-1:0] in_enc,
    input  wire logic [1:0]                in_pin,
    input  wire logic                      in_level,
    input  wire logic [qdv_pkg::TS_W-1:0]  in_ts,
    input  wire qdv_pkg::cmd_t             cmd,
    output qdv_pkg::sts_t                  sts,
    output logic [164:0]                   snap_data
);
    import qdv_pkg::*;

    localparam int EW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int SW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int MD = NUM_ENCODERS * SAMPLE_DEPTH;
    localparam int AW = $clog2(MD);
    localparam logic [SW-1:0] LAST = SW'(SAMPLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(SAMPLE_DEPTH);

    logic [1:0]       ab_reg   [NUM_ENCODERS];
    logic [31:0]      pos_reg  [NUM_ENCODERS];
    logic [SW-1:0]    head_reg [NUM_ENCODERS];
    logic [CW-1:0]    fill_reg [NUM_ENCODERS];
    logic [TS_W-1:0]  lvt_reg  [NUM_ENCODERS];
    logic [31:0]      vel_reg  [NUM_ENCODERS];
    logic             fwd_reg  [NUM_ENCODERS];
    logic             idx_reg  [NUM_ENCODERS];
    logic             upd_reg  [NUM_ENCODERS];
    logic [31:0]      pul_reg  [NUM_ENCODERS];
    logic [31:0]      rev_reg  [NUM_ENCODERS];
    logic [31:0]      err_reg  [NUM_ENCODERS];

    logic [79:0]      ring_mem [MD];
    logic [79:0]      rd_reg;

    logic [EW-1:0]    e_reg;
    logic [1:0]       pin_reg;
    logic             lvl_reg;
    logic [TS_W-1:0]  ts_reg;

    logic [SW-1:0]    sidx_reg;
    logic [CW-1:0]    scnt_reg;
    logic [SW-1:0]    old_reg;
    logic             found_reg;
    logic [TS_W-1:0]  tnew_reg;
    logic [31:0]      pnew_reg;
    logic [1:0]       endph_reg;
    logic [31:0]      mag_reg;
    logic             neg_reg;
    logic [TS_W-1:0]  dt_reg;
    logic [65:0]      num_reg;
    logic [63:0]      den_reg;
    logic [64:0]      rem_reg;
    logic [32:0]      q_reg;
    logic             big_reg;
    logic [6:0]       dcnt_reg;
    logic [31:0]      vnew_reg;

    logic [EW-1:0]    e_in;
    logic [1:0]       ab_old;
    logic [1:0]       ab_new;
    logic             pin_b;
    logic [1:0]       dec;
    logic             step;
    logic [SW-1:0]    h;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [SW-1:0]    prev_idx;
    logic [SW-1:0]    newest;
    logic [TS_W-1:0]  age;
    logic [64:0]      rem_sh;
    logic [64:0]      rem_sub;
    logic             qb;
    logic [32:0]      q_sh;
    logic [32:0]      limit;
    logic [31:0]      qsat;
    logic [31:0]      diff;
    logic [15:0]      ppr;

    assign e_in   = EW'(in_enc);
    assign ab_old = ab_reg[e_reg];
    assign pin_b  = pin_reg[0] ^ cfg.chan_swap;
    assign ab_new = pin_b ? {lvl_reg, ab_old[0]} : {ab_old[1], lvl_reg};
    assign dec    = qdv_decode({ab_old, ab_new});
    assign step   = dec[0] ^ dec[1];
    assign h      = head_reg[e_reg];
    assign wr_addr = AW'(e_reg) * AW'(SAMPLE_DEPTH) + AW'(h);
    assign prev_idx = (sidx_reg == '0) ? LAST : sidx_reg - 1'b1;
    assign newest = (h == '0) ? LAST : h - 1'b1;
    assign age    = ts_reg - rd_reg[79:32];
    assign diff   = pnew_reg - rd_reg[31:0];
    assign ppr    = (cfg.pulses_per_rev == '0) ? 16'd1 : cfg.pulses_per_rev;

    always_comb
    begin
        rd_addr = AW'(e_reg) * AW'(SAMPLE_DEPTH) + AW'(prev_idx);
        if (cmd.end_load || cmd.mul_start)
            rd_addr = AW'(e_reg) * AW'(SAMPLE_DEPTH) + AW'(endph_reg[0] ? old_reg : newest);
    end

    assign rem_sh  = {rem_reg[63:0], num_reg[65]};
    assign qb      = rem_reg[64] || (rem_sh >= {1'b0, den_reg});
    assign rem_sub = qb ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign q_sh    = {q_reg[31:0], qb};
    assign limit   = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
    assign qsat    = (big_reg || q_reg > limit) ? limit[31:0] : q_reg[31:0];

    always_comb
    begin
        sts.due       = (ts_reg - lvt_reg[e_reg]) >= TS_W'(cfg.min_update_us);
        sts.scan_more = scnt_reg < fill_reg[e_reg] && scnt_reg < FULL;
        sts.scan_hit  = age <= TS_W'(cfg.velocity_window_us);
        sts.found     = found_reg;
        sts.dt_zero   = (tnew_reg - rd_reg[79:32]) == '0;
        sts.div_done  = endph_reg == 2'd3 && dcnt_reg == 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_apply && step && pin_reg != PIN_IDX && pin_reg != PIN_NONE)
            ring_mem[wr_addr] <= {ts_reg, pos_reg[e_reg] + (dec[1] ? 32'hFFFFFFFF : 32'd1)};
        rd_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_reg    <= e_in;
            pin_reg  <= in_pin;
            lvl_reg  <= in_level;
            ts_reg   <= in_ts;
            scnt_reg <= '0;
        end
        if (cmd.tick_start)
        begin
            sidx_reg  <= h;
            scnt_reg  <= '0;
            found_reg <= 1'b0;
            endph_reg <= 2'd0;
        end
        if (cmd.scan_load)
            scnt_reg <= scnt_reg + 1'b1;
        if (cmd.scan_eval)
        begin
            sidx_reg <= prev_idx;
            if (sts.scan_hit)
            begin
                old_reg   <= prev_idx;
                found_reg <= 1'b1;
            end
        end
        if (cmd.end_load)
            endph_reg <= 2'd1;
        if (cmd.mul_start)
        begin
            tnew_reg <= rd_reg[79:32];
            pnew_reg <= rd_reg[31:0];
        end
        if (endph_reg == 2'd1 && !cmd.end_load && !cmd.mul_start)
        begin
            endph_reg <= 2'd2;
            dt_reg  <= tnew_reg - rd_reg[79:32];
            neg_reg <= diff[31];
            mag_reg <= diff[31] ? 32'd0 - diff : diff;
        end
        if (endph_reg == 2'd2)
        begin
            endph_reg <= 2'd3;
            num_reg  <= 66'(mag_reg) * 66'(RPM_Q8_SCALE);
            den_reg  <= 64'(ppr) * 64'(dt_reg);
            rem_reg  <= '0;
            q_reg    <= '0;
            big_reg  <= 1'b0;
            dcnt_reg <= 7'd66;
        end
        if (cmd.div_step && endph_reg == 2'd3 && dcnt_reg != 7'd0)
        begin
            rem_reg  <= rem_sub;
            num_reg  <= {num_reg[64:0], 1'b0};
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!big_reg)
            begin
                q_reg   <= q_sh;
                big_reg <= q_sh[32];
            end
        end
        vnew_reg <= neg_reg ? 32'd0 - qsat : qsat;
        if (cmd.snap)
            snap_data <= {err_reg[e_reg], rev_reg[e_reg], pul_reg[e_reg], upd_reg[e_reg],
                          idx_reg[e_reg], fwd_reg[e_reg], vel_reg[e_reg], pos_reg[e_reg],
                          ENC_W'(e_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                ab_reg[i] <= '0; pos_reg[i] <= '0; head_reg[i] <= '0;
                fill_reg[i] <= '0; lvt_reg[i] <= '0; vel_reg[i] <= '0;
                fwd_reg[i] <= 1'b1; idx_reg[i] <= 1'b0; upd_reg[i] <= 1'b0;
                pul_reg[i] <= '0; rev_reg[i] <= '0; err_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.edge_apply)
            begin
                if (pin_reg == PIN_IDX)
                begin
                    if (cfg.index_enable && lvl_reg)
                    begin
                        if (cfg.absolute_mode)
                            pos_reg[e_reg] <= '0;
                        idx_reg[e_reg] <= 1'b1;
                    end
                end
                else if (pin_reg != PIN_NONE)
                begin
                    ab_reg[e_reg] <= ab_new;
                    if (dec == 2'b11)
                        err_reg[e_reg] <= err_reg[e_reg] + 1'b1;
                    else if (step)
                    begin
                        pos_reg[e_reg] <= pos_reg[e_reg] + (dec[1] ? 32'hFFFFFFFF : 32'd1);
                        pul_reg[e_reg] <= pul_reg[e_reg] + 1'b1;
                        if (fwd_reg[e_reg] != !dec[1])
                        begin
                            fwd_reg[e_reg] <= !dec[1];
                            rev_reg[e_reg] <= rev_reg[e_reg] + 1'b1;
                        end
                        head_reg[e_reg] <= (h == LAST) ? '0 : h + 1'b1;
                        if (fill_reg[e_reg] < FULL)
                            fill_reg[e_reg] <= fill_reg[e_reg] + 1'b1;
                        upd_reg[e_reg] <= 1'b1;
                    end
                end
            end
            if (cmd.vel_store)
            begin
                lvt_reg[e_reg] <= ts_reg;
                if (found_reg && endph_reg == 2'd3 && dt_reg != '0)
                    vel_reg[e_reg] <= vnew_reg;
            end
            if (cmd.snap)
            begin
                idx_reg[e_reg] <= 1'b0;
                upd_reg[e_reg] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/quadrature_decoder_with_velocity.sv =====
// Edge word: applied in S_EDGE; the next word is taken back in S_IDLE.
// Tick word: S_TICK then S_SNAP when the update interval has not passed; else
//   the window scan and, if a sample is found, the 66-step restoring divider.
// One word at a time; a held snapshot stalls the core until it is taken.
// Reset: asynchronous, active low; counters clear, forward flag set,
//   ring contents undefined and guarded by per-encoder fill counts.
// ============================================================================
// quadrature_decoder_with_velocity
// Top level: stream ports, APB registers, controller and datapath.
// ============================================================================
`default_nettype none

module quadrature_decoder_with_velocity #(
    parameter int NUM_ENCODERS = 4,
    parameter int SAMPLE_DEPTH = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // encoder_select[1:0], mode[2], pin_select[4:3], pin_level[5],
    // timestamp_us[53:6], zero fill
    input  wire logic [55:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // encoder_out[1:0], position_count[33:2], velocity_rpm_q8[65:34],
    // moving_forward[66], index_seen[67], moved_flag[68],
    // pulse_total[100:69], direction_change_total[132:101],
    // invalid_transition_total[164:133], zero fill
    output logic [167:0]      m_axis_tdata
);
    import qdv_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    sts_t  sts;
    logic  busy;
    logic  in_fire;
    logic  valid_enc;
    logic  out_valid_reg;
    logic  out_free;
    logic [164:0] snap;

    assign pready = 1'b1;
    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign valid_enc = 32'(s_axis_tdata[1:0]) < NUM_ENCODERS;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b0, snap};

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_PPR:  prdata = 32'(cfg_reg.pulses_per_rev);
            REG_ABS:  prdata = 32'(cfg_reg.absolute_mode);
            REG_SWAP: prdata = 32'(cfg_reg.chan_swap);
            REG_IDX:  prdata = 32'(cfg_reg.index_enable);
            REG_WIN:  prdata = 32'(cfg_reg.velocity_window_us);
            REG_MIN:  prdata = 32'(cfg_reg.min_update_us);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulses_per_rev     <= 16'd1024;
            cfg_reg.absolute_mode      <= 1'b0;
            cfg_reg.chan_swap          <= 1'b0;
            cfg_reg.index_enable       <= 1'b0;
            cfg_reg.velocity_window_us <= 24'd100000;
            cfg_reg.min_update_us      <= 24'd1000;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[4:2])
                    REG_PPR:  cfg_reg.pulses_per_rev     <= pwdata[15:0];
                    REG_ABS:  cfg_reg.absolute_mode      <= pwdata[0];
                    REG_SWAP: cfg_reg.chan_swap          <= pwdata[0];
                    REG_IDX:  cfg_reg.index_enable       <= pwdata[0];
                    REG_WIN:  cfg_reg.velocity_window_us <= pwdata[23:0];
                    REG_MIN:  cfg_reg.min_update_us      <= pwdata[23:0];
                    default:  ;
                endcase
            end
            if (cmd.snap)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    qdv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_tick      (s_axis_tdata[2]),
        .in_valid_enc (valid_enc),
        .sts          (sts),
        .out_free     (out_free),
        .busy         (busy),
        .cmd          (cmd)
    );

    qdv_datapath #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .in_enc    (s_axis_tdata[1:0]),
        .in_pin    (s_axis_tdata[4:3]),
        .in_level  (s_axis_tdata[5]),
        .in_ts     (s_axis_tdata[53:6]),
        .cmd       (cmd),
        .sts       (sts),
        .snap_data (snap)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy || !$past(valid_enc))
        else $error("accepted word did not start work");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.snap |-> out_free)
        else $error("snapshot overwrote pending word");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_apply |-> !cmd.snap && !cmd.vel_store)
        else $error("edge and tick work overlap");

endmodule

`default_nettype wire

// ===== tb/quadrature_decoder_with_velocity_test.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_with_velocity_test
// Drives edge and tick words into the decoder under several register
// settings, predicts every snapshot with its own model of the decoder and
// compares each snapshot field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_with_velocity_test;
    import qdv_pkg::*;

    localparam int NENC = 4;
    localparam int DEPTH = 10;
    localparam int LIMIT = 2000000;
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [2:0]  fill;
        logic [31:0] errors;
        logic [31:0] reversals;
        logic [31:0] pulses;
        logic        updated;
        logic        seen;
        logic        forward;
        logic [31:0] velocity;
        logic [31:0] position;
        logic [1:0]  enc;
    } snapshot_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;

    quadrature_decoder_with_velocity u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register copies
    logic [15:0] c_ppr;
    logic        c_abs, c_swap, c_idx;
    logic [23:0] c_win, c_min;

    // decoder state copies
    logic [1:0]  m_ab [NENC];
    logic [31:0] m_pos [NENC];
    logic [47:0] m_st [NENC][DEPTH];
    logic [31:0] m_sp [NENC][DEPTH];
    int          m_head [NENC];
    int          m_fill [NENC];
    logic [47:0] m_lvt [NENC];
    logic [31:0] m_vel [NENC];
    logic        m_fwd [NENC];
    logic        m_seen [NENC];
    logic        m_upd [NENC];
    logic [31:0] m_pulses [NENC];
    logic [31:0] m_revs [NENC];
    logic [31:0] m_errs [NENC];

    logic [55:0] word_queue [$];
    snapshot_t   snapshots_due [$];
    int          failures = 0;
    int          words_sent = 0;
    int          snapshots_seen = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;

    // stimulus generator state
    logic [1:0]  g_ab [NENC];
    logic [47:0] g_ts [NENC];
    bit          g_fwd [NENC];
    int          g_span = 3000;

    task automatic reset_model();
        c_ppr = 16'd1024; c_abs = 0; c_swap = 0; c_idx = 0;
        c_win = 24'd100000; c_min = 24'd1000;
        for (int e = 0; e < NENC; e++)
        begin
            m_ab[e] = 0; m_pos[e] = 0; m_head[e] = 0; m_fill[e] = 0;
            m_lvt[e] = 0; m_vel[e] = 0; m_fwd[e] = 1; m_seen[e] = 0;
            m_upd[e] = 0; m_pulses[e] = 0; m_revs[e] = 0; m_errs[e] = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                m_st[e][i] = 0;
                m_sp[e][i] = 0;
            end
        end
    endtask

    function automatic logic [31:0] rpm_q8(logic [31:0] diff, logic [63:0] den);
        logic         neg;
        logic [31:0]  mag;
        logic [127:0] q;
        logic [127:0] lim;
        begin
            neg = diff[31];
            mag = neg ? -diff : diff;
            q = ({96'd0, mag} * {94'd0, RPM_Q8_SCALE}) / {64'd0, den};
            lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
            if (q > lim)
                q = lim;
            return neg ? -q[31:0] : q[31:0];
        end
    endfunction

    task automatic velocity_update(int e, logic [47:0] ts);
        int          h, idx, oldest, newest;
        bit          found;
        logic [47:0] dt;
        logic [47:0] age;
        logic [63:0] ppr;
        h = m_head[e];
        idx = h;
        oldest = 0;
        found = 0;
        if (ts - m_lvt[e] < {24'd0, c_min})
            return;
        for (int i = 0; i < m_fill[e]; i++)
        begin
            idx = (idx + DEPTH - 1) % DEPTH;
            age = ts - m_st[e][idx];
            if (age > {24'd0, c_win})
                break;
            oldest = idx;
            found = 1;
        end
        if (found)
        begin
            newest = (h + DEPTH - 1) % DEPTH;
            dt = m_st[e][newest] - m_st[e][oldest];
            ppr = (c_ppr == 0) ? 64'd1 : {48'd0, c_ppr};
            if (dt != 0)
                m_vel[e] = rpm_q8(m_sp[e][newest] - m_sp[e][oldest], ppr * {16'd0, dt});
        end
        m_lvt[e] = ts;
    endtask

    task automatic pin_update(int e, logic [1:0] pin, logic lvl, logic [47:0] ts);
        logic [1:0] nab;
        logic [3:0] code;
        int         dir;
        dir = 0;
        if (pin == PIN_IDX)
        begin
            if (c_idx && lvl)
            begin
                if (c_abs)
                    m_pos[e] = 0;
                m_seen[e] = 1;
            end
            return;
        end
        if (pin == PIN_NONE)
            return;
        if (c_swap)
            pin = (pin == PIN_A) ? PIN_B : PIN_A;
        nab = (pin == PIN_A) ? {m_ab[e][1], lvl} : {lvl, m_ab[e][0]};
        code = {m_ab[e], nab};
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:  dir = 1;
            4'd2, 4'd4, 4'd11, 4'd13: dir = -1;
            4'd3, 4'd6, 4'd9, 4'd12:  m_errs[e]++;
            default:                  dir = 0;
        endcase
        if (dir != 0)
        begin
            m_pos[e] += (dir > 0) ? 32'd1 : 32'hFFFFFFFF;
            m_pulses[e]++;
            if ((dir > 0) != m_fwd[e])
            begin
                m_fwd[e] = (dir > 0);
                m_revs[e]++;
            end
            m_st[e][m_head[e]] = ts;
            m_sp[e][m_head[e]] = m_pos[e];
            m_head[e] = (m_head[e] + 1) % DEPTH;
            if (m_fill[e] < DEPTH)
                m_fill[e]++;
            m_upd[e] = 1;
        end
        m_ab[e] = nab;
    endtask

    task automatic decode_word(logic [55:0] w);
        int          e;
        snapshot_t   s;
        e = w[1:0];
        if (w[2] == MODE_EDGE)
        begin
            pin_update(e, w[4:3], w[5], w[53:6]);
            return;
        end
        velocity_update(e, w[53:6]);
        s = '0;
        s.enc = w[1:0];
        s.position = m_pos[e];
        s.velocity = m_vel[e];
        s.forward = m_fwd[e];
        s.seen = m_seen[e];
        s.updated = m_upd[e];
        s.pulses = m_pulses[e];
        s.reversals = m_revs[e];
        s.errors = m_errs[e];
        snapshots_due.push_back(s);
        m_seen[e] = 0;
        m_upd[e] = 0;
    endtask

    // driver
    always @(posedge clk)
    begin
        logic [55:0] nxt;
        logic        v;
        cycles <= cycles + 1;
        if (s_axis_tvalid && s_axis_tready)
        begin
            decode_word(s_axis_tdata);
            words_sent++;
        end
        v = s_axis_tvalid && !s_axis_tready;
        nxt = s_axis_tdata;
        if (!v && rst_n && word_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 19))
        begin
            nxt = word_queue.pop_front();
            v = 1'b1;
        end
        s_axis_tvalid <= v;
        s_axis_tdata <= nxt;
    end

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            failures++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        snapshot_t a;
        snapshot_t x;
        if (m_axis_tvalid && m_axis_tready)
        begin
            a = m_axis_tdata;
            snapshots_seen++;
            if (snapshots_due.size() == 0)
            begin
                $display("%0t: unexpected snapshot, expected none, actual %h", $time, a);
                failures++;
            end
            else
            begin
                x = snapshots_due.pop_front();
                check_field("encoder_out", 32'(x.enc), 32'(a.enc));
                check_field("position_count", x.position, a.position);
                check_field("velocity_rpm_q8", x.velocity, a.velocity);
                check_field("moving_forward", 32'(x.forward), 32'(a.forward));
                check_field("index_seen", 32'(x.seen), 32'(a.seen));
                check_field("moved_flag", 32'(x.updated), 32'(a.updated));
                check_field("pulse_total", x.pulses, a.pulses);
                check_field("direction_change_total", x.reversals, a.reversals);
                check_field("invalid_transition_total", x.errors, a.errors);
            end
        end
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_cnt = 600;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout with %0d snapshots outstanding", $time, snapshots_due.size());
            $display("quadrature_decoder_with_velocity test failed");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_PPR:  c_ppr = value[15:0];
            REG_ABS:  c_abs = value[0];
            REG_SWAP: c_swap = value[0];
            REG_IDX:  c_idx = value[0];
            REG_WIN:  c_win = value[23:0];
            REG_MIN:  c_min = value[23:0];
            default:  ;
        endcase
    endtask

    task automatic configure(logic [15:0] ppr, logic ab, logic sw, logic ix,
                             logic [23:0] win, logic [23:0] mn);
        apb_write(REG_PPR, {16'd0, ppr});
        apb_write(REG_ABS, {31'd0, ab});
        apb_write(REG_SWAP, {31'd0, sw});
        apb_write(REG_IDX, {31'd0, ix});
        apb_write(REG_WIN, {8'd0, win});
        apb_write(REG_MIN, {8'd0, mn});
    endtask

    task automatic add_word(int e, logic md, logic [1:0] pin, logic lvl, logic [47:0] ts);
        word_queue.push_back({2'b00, ts, lvl, pin, md, e[1:0]});
    endtask

    task automatic add_step(int e, bit fwd);
        logic [1:0] pin;
        pin = ((g_ab[e][0] == g_ab[e][1]) == fwd) ? PIN_A : PIN_B;
        g_ab[e][pin] = ~g_ab[e][pin];
        g_ts[e] += 48'($urandom_range(1, g_span));
        add_word(e, MODE_EDGE, pin, g_ab[e][pin], g_ts[e]);
    endtask

    task automatic add_tick(int e);
        g_ts[e] += 48'($urandom_range(0, g_span));
        add_word(e, MODE_TICK, PIN_A, 1'($urandom_range(0, 1)), g_ts[e]);
    endtask

    task automatic add_random(int n);
        int e, r;
        for (int k = 0; k < n; k++)
        begin
            e = $urandom_range(0, NENC - 1);
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                if ($urandom_range(0, 99) < 10)
                    g_fwd[e] = !g_fwd[e];
                add_step(e, g_fwd[e]);
            end
            else if (r < 82)
                add_tick(e);
            else if (r < 88)
                add_word(e, MODE_EDGE, PIN_IDX, 1'($urandom_range(0, 1)), g_ts[e]);
            else if (r < 92)
                add_word(e, MODE_EDGE, 2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         g_ts[e]);
            else if (r < 95)
                add_word(e, MODE_EDGE, PIN_NONE, 1'($urandom_range(0, 1)), g_ts[e]);
            else
                add_word(e, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 48'({$urandom, $urandom}));
        end
    endtask

    task automatic drain();
        wait (word_queue.size() == 0 && !s_axis_tvalid && snapshots_due.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        reset_model();
        for (int e = 0; e < NENC; e++)
        begin
            g_ab[e] = 0;
            g_ts[e] = 48'd2000;
            g_fwd[e] = 1;
        end
        g_ts[3] = 48'hFFFFFFFFF000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: defaults, forward then reverse, ticks, ignored words
        add_tick(0);
        for (int i = 0; i < 5; i++) add_step(0, 1);
        add_tick(0);
        for (int i = 0; i < 3; i++) add_step(0, 0);
        g_ts[0] += 48'd2000;
        add_tick(0);
        add_word(1, MODE_EDGE, PIN_IDX, 1'b1, g_ts[1]);
        add_word(1, MODE_EDGE, PIN_NONE, 1'b1, g_ts[1]);
        add_tick(1);
        for (int i = 0; i < 6; i++) add_step(3, 0);
        add_tick(3);
        add_tick(2);
        drain();

        // index enabled, absolute mode, swapped, no interval, widest window
        configure(16'd1, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 24'd0);
        add_word(2, MODE_EDGE, PIN_IDX, 1'b1, g_ts[2]);
        add_word(2, MODE_EDGE, PIN_IDX, 1'b0, g_ts[2]);
        add_tick(2);
        quiet = 1'b1;
        add_random(130);
        drain();
        quiet = 1'b0;

        // largest ppr, one-microsecond window
        configure(16'hFFFF, 1'b0, 1'b0, 1'b1, 24'd1, 24'd0);
        g_span = 2;
        add_random(130);
        drain();

        // zero ppr and zero window; receiver holds off
        configure(16'd0, 1'b1, 1'b0, 1'b0, 24'd0, 24'd0);
        hold_req++;
        add_random(130);
        drain();

        // long interval
        g_span = 3000;
        configure(16'd1024, 1'b0, 1'b1, 1'b0, 24'd100000, 24'hFFFFFF);
        add_random(130);
        drain();

        // random settings
        for (int p = 0; p < 2; p++)
        begin
            configure(16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 24'($urandom_range(1, 50000)),
                      24'($urandom_range(0, 5000)));
            g_span = $urandom_range(1, 8000);
            add_random(130);
            drain();
        end

        $display("Covered %0d words and %0d snapshots over seven register settings,",
                 words_sent, snapshots_seen);
        $display("including a long receiver hold-off and timestamp wrap-around.");
        if (failures == 0)
            $display("quadrature_decoder_with_velocity test passed");
        else
            $display("quadrature_decoder_with_velocity test failed");
        $finish;
    end

endmodule

`default_nettype wire
